### rtl/core/psch_pkg.sv
// ----------------------------------------------------------------------------
// psch_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psch_pkg;

   // default job table depth
   localparam int MAX_PROCS_DEF = 16;

   localparam int ID_W    = 16;
   localparam int ARR_W   = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int TICK_W  = 32;

   // request tdata: proc_id, arrival_tick, burst_len, prio_level (56 bits used)
   localparam int REQ_TDATA_W = 56;
   // response tdata: 148 bits used, padded to 19 bytes
   localparam int RSP_USED_W  = 148;
   localparam int RSP_TDATA_W = 152;

   // request kinds carried on req_tuser
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // one job table entry
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [ARR_W-1:0]   arrival;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] remaining;
      logic               started;
      logic [TICK_W-1:0]  first_run;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // control from sequencer to the selection unit
   typedef struct packed {
      logic clear;   // start of a new scan
      logic valid;   // RAM read data is a live entry this cycle
   } sel_ctl_type;

endpackage

### rtl/core/psch_ram.sv
// ----------------------------------------------------------------------------
// psch_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module psch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/psch_select.sv
// ----------------------------------------------------------------------------
// psch_select
// Running best-candidate register for the table scan: ready filter plus
// priority / arrival compare, one entry per cycle.
// ----------------------------------------------------------------------------
module psch_select #(
   parameter int MAX_PROCS = psch_pkg::MAX_PROCS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  psch_pkg::sel_ctl_type        ctl,
   input  logic [$clog2(MAX_PROCS)-1:0] cand_index,
   input  psch_pkg::entry_type          cand_rec,
   input  logic [psch_pkg::TICK_W-1:0]  tick,
   output logic                         best_found,
   output logic [$clog2(MAX_PROCS)-1:0] best_index,
   output psch_pkg::entry_type          best_rec
);

   localparam int IDX_W = $clog2(MAX_PROCS);

   logic                found_ff, found_in;
   logic [IDX_W-1:0]    index_ff, index_in;
   psch_pkg::entry_type rec_ff, rec_in;
   logic                ready;
   logic                better;

   // ready: work left and already arrived
   assign ready = (cand_rec.remaining != '0) &&
                  ({{(psch_pkg::TICK_W-psch_pkg::ARR_W){1'b0}}, cand_rec.arrival} <= tick);

   // strict compare keeps the earlier table entry on a full tie
   assign better = !found_ff ||
                   (cand_rec.prio < rec_ff.prio) ||
                   ((cand_rec.prio == rec_ff.prio) && (cand_rec.arrival < rec_ff.arrival));

   always_comb begin
      found_in = found_ff;
      index_in = index_ff;
      rec_in   = rec_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.valid && ready && better) begin
         found_in = 1'b1;
         index_in = cand_index;
         rec_in   = cand_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      index_ff <= index_in;
      rec_ff   <= rec_in;
   end

   assign best_found = found_ff;
   assign best_index = index_ff;
   assign best_rec   = rec_ff;

endmodule

### rtl/core/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a RAM-held job table.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-------------------------------------
//   req     | in  | req_tvalid/req_tready | tuser: mode; tdata: job fields
//   rsp     | out | rsp_tvalid/rsp_tready | tdata: slot report (tick only)
//
// Load: the entry is written to the table RAM at accept; no response.
// Tick: accept, one RAM read per entry, read latency, scan close, then update/report;
// entries are read one at a time through the table RAM's single read port.
// The update cycle waits while the response register is full; the next
// transaction is accepted after it, even with rsp stalled.
// Synchronous active-high reset; no table clearing, only entries below entry_count are read.
//
module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = psch_pkg::MAX_PROCS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] proc_id, [31:16] arrival_tick, [47:32] burst_len, [55:48] prio_level
   input  logic [psch_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] mode
   input  logic                             req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] idle, [16:1] run_id, [48:17] slot_tick, [49] new_segment,
   // [50] finished, [82:51] fin_first_run, [114:83] fin_end,
   // [146:115] fin_turnaround, [147] all_finished, [151:148] zero
   output logic [psch_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TW    = psch_pkg::TICK_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [CNT_W-1:0] fin_count_ff, fin_count_in;
   logic [TW-1:0]    tick_ff, tick_in;
   logic [IDX_W-1:0] last_index_ff, last_index_in;
   logic             last_valid_ff, last_valid_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_tag_ff, rd_tag_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [psch_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // request fields
   logic [psch_pkg::ID_W-1:0]    req_id;
   logic [psch_pkg::ARR_W-1:0]   req_arrival;
   logic [psch_pkg::BURST_W-1:0] req_burst;
   logic [psch_pkg::PRIO_W-1:0]  req_prio;

   assign req_id      = req_tdata[15:0];
   assign req_arrival = req_tdata[31:16];
   assign req_burst   = req_tdata[47:32];
   assign req_prio    = req_tdata[55:48];

   // RAM ports
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   psch_pkg::entry_type ram_wdata;
   logic                ram_re;
   psch_pkg::entry_type ram_rdata;

   // selection unit
   psch_pkg::sel_ctl_type sel_ctl;
   logic                  best_found;
   logic [IDX_W-1:0]      best_index;
   psch_pkg::entry_type   best_rec;

   logic req_fire, load_ok, issuing, out_free, final_go;

   // final-cycle results
   logic                          new_seg, job_done;
   logic [TW-1:0]                 first_run, end_tick, turnaround;
   logic [CNT_W-1:0]              fin_count_next;
   logic                          all_done;
   psch_pkg::entry_type           upd_rec;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_ok    = (entry_count_ff < CNT_W'(MAX_PROCS)) && (req_burst != '0);
   assign issuing    = (state_ff == ST_SCAN) && (rd_idx_ff < entry_count_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign final_go   = (state_ff == ST_FINAL) && out_free;

   // slot report arithmetic
   assign new_seg    = !last_valid_ff || (last_index_ff != best_index);
   assign job_done   = (best_rec.remaining == psch_pkg::BURST_W'(1));
   assign first_run  = best_rec.started ? best_rec.first_run : tick_ff;
   assign end_tick   = tick_ff + TW'(1);
   assign turnaround = end_tick - {{(TW-psch_pkg::ARR_W){1'b0}}, best_rec.arrival};
   assign fin_count_next = fin_count_ff + CNT_W'(best_found && job_done);
   assign all_done   = (fin_count_next == entry_count_ff);

   always_comb begin
      upd_rec           = best_rec;
      upd_rec.remaining = best_rec.remaining - psch_pkg::BURST_W'(1);
      upd_rec.started   = 1'b1;
      upd_rec.first_run = first_run;
   end

   // RAM write: load in the accept cycle, write-back in the final cycle.
   // The two never coincide, and a scan read never overlaps a write,
   // so no forwarding is needed.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = best_index;
      ram_wdata = upd_rec;
      if (req_fire && (req_tuser == psch_pkg::MODE_LOAD)) begin
         ram_we              = load_ok;
         ram_waddr           = entry_count_ff[IDX_W-1:0];
         ram_wdata.id        = req_id;
         ram_wdata.arrival   = req_arrival;
         ram_wdata.prio      = req_prio;
         ram_wdata.remaining = req_burst;
         ram_wdata.started   = 1'b0;
         ram_wdata.first_run = '0;
      end else if (final_go) begin
         ram_we = best_found;
      end
   end

   assign ram_re        = issuing;
   assign sel_ctl.clear = req_fire && (req_tuser == psch_pkg::MODE_TICK);
   assign sel_ctl.valid = rd_vld_ff;

   // sequencer and state update
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      fin_count_in   = fin_count_ff;
      tick_in        = tick_ff;
      last_index_in  = last_index_ff;
      last_valid_in  = last_valid_ff;
      rd_idx_in      = rd_idx_ff;
      rd_vld_in      = issuing;
      rd_tag_in      = rd_idx_ff[IDX_W-1:0];
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == psch_pkg::MODE_LOAD) begin
                  if (load_ok) begin
                     entry_count_in = entry_count_ff + CNT_W'(1);
                  end
               end else begin
                  rd_idx_in = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[48:17] = tick_ff;
               if (best_found) begin
                  rsp_data_in[16:1] = best_rec.id;
                  rsp_data_in[49]   = new_seg;
                  if (job_done) begin
                     rsp_data_in[50]      = 1'b1;
                     rsp_data_in[82:51]   = first_run;
                     rsp_data_in[114:83]  = end_tick;
                     rsp_data_in[146:115] = turnaround;
                  end
                  last_index_in = best_index;
                  last_valid_in = 1'b1;
                  fin_count_in  = fin_count_next;
               end else begin
                  rsp_data_in[0] = 1'b1;
                  last_valid_in  = 1'b0;
               end
               rsp_data_in[147] = all_done;
               tick_in          = end_tick;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         fin_count_ff   <= '0;
         tick_ff        <= '0;
         last_index_ff  <= '0;
         last_valid_ff  <= 1'b0;
         rd_idx_ff      <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         fin_count_ff   <= fin_count_in;
         tick_ff        <= tick_in;
         last_index_ff  <= last_index_in;
         last_valid_ff  <= last_valid_in;
         rd_idx_ff      <= rd_idx_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rd_tag_ff   <= rd_tag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   psch_ram #(
      .WIDTH (psch_pkg::ENTRY_W),
      .DEPTH (MAX_PROCS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   psch_select #(
      .MAX_PROCS (MAX_PROCS)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sel_ctl),
      .cand_index (rd_tag_ff),
      .cand_rec   (ram_rdata),
      .tick       (tick_ff),
      .best_found (best_found),
      .best_index (best_index),
      .best_rec   (best_rec)
   );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the preemptive priority scheduler. A driver streams
// job loads and scheduler ticks into the block. A predictor in the bench keeps
// its own job table and works out the slot report that each tick owes. A
// monitor compares every report field by field. Both sides stall at random,
// the receiver holds off once long enough to back up the request side, and
// the sender once waits for every outstanding report before it goes on.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int TABLE_DEPTH = psch_pkg::MAX_PROCS_DEF;
   localparam int TOTAL_ITEMS = 1500;
   localparam int TW          = psch_pkg::TICK_W;

   // one request transaction as queued for the driver
   typedef struct {
      logic                         mode;
      logic [psch_pkg::ID_W-1:0]    id;
      logic [psch_pkg::ARR_W-1:0]   arrival;
      logic [psch_pkg::BURST_W-1:0] burst;
      logic [psch_pkg::PRIO_W-1:0]  prio;
      bit                           drain_first;  // hold until every report is in
   } job_req_type;

   // rsp_tdata layout, MSB first, so a cast unpacks it
   typedef struct packed {
      logic [3:0]                pad;
      logic                      all_finished;
      logic [TW-1:0]             fin_turnaround;
      logic [TW-1:0]             fin_end;
      logic [TW-1:0]             fin_first_run;
      logic                      finished;
      logic                      new_segment;
      logic [TW-1:0]             slot_tick;
      logic [psch_pkg::ID_W-1:0] run_id;
      logic                      idle;
   } slot_report_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [psch_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             req_tuser  = psch_pkg::MODE_LOAD;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [psch_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   preemptive_priority_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Predictor: the bench's own job table
   // --------------------------------------------------------------------------
   logic [psch_pkg::ID_W-1:0]    tbl_id       [TABLE_DEPTH];
   logic [psch_pkg::ARR_W-1:0]   tbl_arrival  [TABLE_DEPTH];
   logic [psch_pkg::PRIO_W-1:0]  tbl_prio     [TABLE_DEPTH];
   logic [psch_pkg::BURST_W-1:0] tbl_left     [TABLE_DEPTH];
   bit                           tbl_started  [TABLE_DEPTH];
   logic [TW-1:0]                tbl_first_run[TABLE_DEPTH];
   int unsigned                  jobs_loaded  = 0;
   int unsigned                  jobs_done    = 0;
   logic [TW-1:0]                sched_tick   = '0;
   int unsigned                  prev_pick    = 0;
   bit                           prev_ran     = 1'b0;

   slot_report_type slot_reports_due[$];   // reports owed, oldest first
   job_req_type     pending_reqs[$];       // transactions not yet offered
   int              fail_count = 0;

   // Apply one accepted transaction; a tick queues the report it owes.
   task automatic predict_slot(input job_req_type rq);
      slot_report_type rep;
      int unsigned     k;
      int unsigned     pick;
      bit              found;
      logic [TW-1:0]   end_tick;
      if (rq.mode == psch_pkg::MODE_LOAD) begin
         // full table and zero-burst loads are dropped
         if (jobs_loaded < TABLE_DEPTH && rq.burst != 0) begin
            tbl_id[jobs_loaded]        = rq.id;
            tbl_arrival[jobs_loaded]   = rq.arrival;
            tbl_prio[jobs_loaded]      = rq.prio;
            tbl_left[jobs_loaded]      = rq.burst;
            tbl_started[jobs_loaded]   = 1'b0;
            tbl_first_run[jobs_loaded] = '0;
            jobs_loaded++;
         end
         return;
      end
      found = 1'b0;
      pick  = 0;
      // lowest prio number, then earliest arrival, then earliest entry
      for (k = 0; k < jobs_loaded; k++) begin
         if (tbl_left[k] != 0 && {16'b0, tbl_arrival[k]} <= sched_tick) begin
            if (!found || tbl_prio[k] < tbl_prio[pick] ||
                (tbl_prio[k] == tbl_prio[pick] && tbl_arrival[k] < tbl_arrival[pick])) begin
               pick  = k;
               found = 1'b1;
            end
         end
      end
      rep = '0;
      rep.slot_tick = sched_tick;
      if (!found) begin
         rep.idle = 1'b1;
         prev_ran = 1'b0;
      end else begin
         rep.run_id      = tbl_id[pick];
         rep.new_segment = !prev_ran || prev_pick != pick;
         if (!tbl_started[pick]) begin
            tbl_started[pick]   = 1'b1;
            tbl_first_run[pick] = sched_tick;
         end
         tbl_left[pick] = tbl_left[pick] - 1'b1;
         prev_pick = pick;
         prev_ran  = 1'b1;
         if (tbl_left[pick] == 0) begin
            end_tick           = sched_tick + 1'b1;
            jobs_done++;
            rep.finished       = 1'b1;
            rep.fin_first_run  = tbl_first_run[pick];
            rep.fin_end        = end_tick;
            rep.fin_turnaround = end_tick - {16'b0, tbl_arrival[pick]};
         end
      end
      sched_tick       = sched_tick + 1'b1;
      rep.all_finished = (jobs_done == jobs_loaded);
      slot_reports_due.push_back(rep);
   endtask

   task automatic check_field(input string name, input logic [TW-1:0] want,
                              input logic [TW-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_slot(input slot_report_type got);
      slot_report_type want;
      if (slot_reports_due.size() == 0) begin
         $error("slot report with no tick outstanding: 0x%0h", got);
         fail_count++;
         return;
      end
      want = slot_reports_due.pop_front();
      check_field("idle",           TW'(want.idle),           TW'(got.idle));
      check_field("run_id",         TW'(want.run_id),         TW'(got.run_id));
      check_field("slot_tick",      want.slot_tick,           got.slot_tick);
      check_field("new_segment",    TW'(want.new_segment),    TW'(got.new_segment));
      check_field("finished",       TW'(want.finished),       TW'(got.finished));
      check_field("fin_first_run",  want.fin_first_run,       got.fin_first_run);
      check_field("fin_end",        want.fin_end,             got.fin_end);
      check_field("fin_turnaround", want.fin_turnaround,      got.fin_turnaround);
      check_field("all_finished",   TW'(want.all_finished),   TW'(got.all_finished));
      check_field("pad",            TW'(want.pad),            TW'(got.pad));
   endtask

   // --------------------------------------------------------------------------
   // Stimulus planning: tracks table fill and tick count ahead of the DUT
   // --------------------------------------------------------------------------
   int unsigned plan_entries = 0;
   int unsigned plan_tick    = 0;
   int unsigned plan_items   = 0;   // ticks plus loads that take a table slot
   bit          drain_next   = 1'b0;

   task automatic queue_load(input logic [15:0] id, input logic [15:0] arr,
                             input logic [15:0] burst, input logic [7:0] prio);
      job_req_type rq;
      rq = '{psch_pkg::MODE_LOAD, id, arr, burst, prio, drain_next};
      drain_next = 1'b0;
      pending_reqs.push_back(rq);
      if (plan_entries < TABLE_DEPTH && burst != 0) begin
         plan_entries++;
         plan_items++;
      end
   endtask

   task automatic queue_ticks(input int unsigned n);
      job_req_type rq;
      repeat (n) begin
         rq.mode        = psch_pkg::MODE_TICK;
         rq.id          = 16'($urandom);   // payload is don't-care on a tick
         rq.arrival     = 16'($urandom);
         rq.burst       = 16'($urandom);
         rq.prio        = 8'($urandom);
         rq.drain_first = drain_next;
         drain_next     = 1'b0;
         pending_reqs.push_back(rq);
         plan_tick++;
         plan_items++;
      end
   endtask

   // --------------------------------------------------------------------------
   // Driver: offers queued transactions, predicts each one as it is accepted
   // --------------------------------------------------------------------------
   job_req_type offered_req;
   int unsigned accepted_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_slot(offered_req);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            // ~20% gaps, except a quiet stretch of back-to-back transactions
            if (pending_reqs.size() == 0 ||
                ((accepted_count < 400 || accepted_count > 700) &&
                 $urandom_range(0, 99) < 20) ||
                (pending_reqs[0].drain_first && slot_reports_due.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               offered_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {offered_req.prio, offered_req.burst,
                              offered_req.arrival, offered_req.id};
               req_tuser  <= offered_req.mode;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: random backpressure, one long hold-off, report checking
   // --------------------------------------------------------------------------
   int unsigned reports_seen = 0;
   int unsigned hold_cycles  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_slot(slot_report_type'(rsp_tdata));
            reports_seen++;
            // long hold-off: request side keeps offering and must stall
            if (reports_seen == 200) hold_cycles = 300;
         end
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (reports_seen >= 500 && reports_seen < 800) ||
                          $urandom_range(0, 99) >= 20;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Sequence, reset and end of run
   // --------------------------------------------------------------------------
   initial begin
      int          arr;
      int unsigned cluster;
      bit          wide_job_loaded;
      bit          drain_planned;

      // directed: empty table, dropped zero burst, preemption, ties
      queue_ticks(1);                                   // idle, nothing loaded
      queue_load(16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF);  // zero burst: dropped
      queue_load(16'h0001, 16'h0000, 16'h0003, 8'hFF);  // weakest prio, runs first
      queue_load(16'h0002, 16'h0002, 16'h0002, 8'h00);  // arrives at 2, preempts
      queue_ticks(6);                                   // ends with an idle slot
      queue_load(16'hABCD, 16'h0003, 16'h0001, 8'h05);  // arrival already past
      queue_load(16'h5432, 16'h0003, 16'h0001, 8'h05);  // full tie: entry order
      queue_load(16'h0000, 16'h0000, 16'h0001, 8'h05);  // earlier arrival wins
      queue_load(16'h8000, 16'h000C, 16'h0001, 8'h00);  // not ready until 12
      queue_ticks(6);

      // random: clustered loads with small bursts and close arrivals so jobs
      // overlap and preempt; a table slot is kept for a job with every field
      // at its top value, which never arrives
      wide_job_loaded = 1'b0;
      drain_planned   = 1'b0;
      while (plan_items < TOTAL_ITEMS) begin
         if (plan_items >= 900 && !drain_planned) begin
            drain_next    = 1'b1;
            drain_planned = 1'b1;
         end
         if (plan_items >= 1000 && !wide_job_loaded) begin
            queue_load(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
            wide_job_loaded = 1'b1;
         end else if (plan_entries < TABLE_DEPTH - 3 && $urandom_range(0, 99) < 2) begin
            cluster = $urandom_range(1, 3);
            repeat (cluster) begin
               arr = int'(plan_tick) + int'($urandom_range(0, 20)) - 8;
               if (arr < 0) arr = 0;
               queue_load(16'($urandom), 16'(arr), 16'($urandom_range(1, 40)),
                          ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom_range(0, 255)));
            end
         end else if ($urandom_range(0, 99) < 2) begin
            // noise: zero burst, or anything once the table is full
            queue_load(16'($urandom), 16'($urandom),
                       (plan_entries >= TABLE_DEPTH) ? 16'($urandom) : 16'h0000,
                       8'($urandom));
         end else begin
            queue_ticks(1);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every transaction accepted and every report in, then let it settle
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || slot_reports_due.size() != 0);
      repeat (64) @(posedge clock);

      if (fail_count == 0 && slot_reports_due.size() == 0) begin
         $display("[preemptive_priority_scheduler] OK");
      end else begin
         $display("[preemptive_priority_scheduler] ERROR");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("[preemptive_priority_scheduler] ERROR");
      $finish;
   end

endmodule
